@@ src/mbp_pkg.sv @@
// Package for the maximum bottleneck path block.
// Holds default sizes, configuration register indexes, the datapath operation codes
// and the command and status structs. Depends on nothing.
package mbp_pkg;

    localparam int unsigned DEF_MAX_NODES   = 1024;
    localparam int unsigned DEF_MAX_EDGES   = 4096;
    localparam int unsigned DEF_WEIGHT_BITS = 32;

    localparam int unsigned NODE_FIELD_BITS = 10;
    localparam int unsigned COUNT_REG_BITS  = 11;
    localparam int unsigned RESULT_BITS     = 32;
    localparam int unsigned CFG_IDX_BITS    = 2;
    localparam int unsigned CFG_DATA_BITS   = 11;

    localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SOURCE_NODE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_NODE = 2'd2;

    localparam logic [COUNT_REG_BITS-1:0] NODE_COUNT_RESET = 11'd1024;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT_BEGIN,
        OP_INIT_STEP,
        OP_SCAN_BEGIN,
        OP_EDGE_RD,
        OP_EDGE_USE,
        OP_PAR_RD,
        OP_STEP,
        OP_ROOT_A_EDGE,
        OP_ROOT_A_QUERY,
        OP_ROOT_B,
        OP_CUR_SRC,
        OP_SZ_RD_A,
        OP_SZ_RD_B,
        OP_UNION,
        OP_FOUND,
        OP_NOT_FOUND
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic query_ok;
        logic init_last;
        logic merge_hit;
        logic scan_done;
        logic root_hit;
        logic same_root;
        logic thr_valid;
        logic nxt_valid;
    } t_sts;

endpackage

@@ src/mbp_in_if.sv @@
// Input channel interface: one edge word with valid and ready.
// Uses the field widths from mbp_pkg.
interface mbp_in_if #(
    parameter int unsigned WEIGHT_BITS = mbp_pkg::DEF_WEIGHT_BITS
);
    logic                                  valid;
    logic                                  ready;
    logic [mbp_pkg::NODE_FIELD_BITS-1:0]   end_a;
    logic [mbp_pkg::NODE_FIELD_BITS-1:0]   end_b;
    logic [WEIGHT_BITS-1:0]                weight;
    logic                                  last_edge;

    modport source (output valid, end_a, end_b, weight, last_edge, input ready);
    modport sink   (input valid, end_a, end_b, weight, last_edge, output ready);
endinterface

@@ src/mbp_out_if.sv @@
// Output channel interface: one result word with valid and ready.
// Uses the field widths from mbp_pkg.
interface mbp_out_if;
    logic                              valid;
    logic                              ready;
    logic                              found;
    logic [mbp_pkg::RESULT_BITS-1:0]   bottleneck;

    modport source (output valid, found, bottleneck, input ready);
    modport sink   (input valid, found, bottleneck, output ready);
endinterface

@@ src/mbp_datapath.sv @@
// Datapath: configuration registers, edge store, union-find forest and the
// threshold and result registers. Executes one command per cycle; uses mbp_pkg.
module mbp_datapath #(
    parameter int unsigned MAX_NODES   = mbp_pkg::DEF_MAX_NODES,
    parameter int unsigned MAX_EDGES   = mbp_pkg::DEF_MAX_EDGES,
    parameter int unsigned WEIGHT_BITS = mbp_pkg::DEF_WEIGHT_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [mbp_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [mbp_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  mbp_pkg::t_cmd                         i_cmd,
    input  logic [mbp_pkg::NODE_FIELD_BITS-1:0]   i_end_a,
    input  logic [mbp_pkg::NODE_FIELD_BITS-1:0]   i_end_b,
    input  logic [WEIGHT_BITS-1:0]                i_weight,
    output mbp_pkg::t_sts                         o_sts,
    output logic                                  o_found,
    output logic [mbp_pkg::RESULT_BITS-1:0]       o_bottleneck
);
    import mbp_pkg::*;

    localparam int unsigned NB = $clog2(MAX_NODES);
    localparam int unsigned NC = $clog2(MAX_NODES + 1);
    localparam int unsigned EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int unsigned EC = $clog2(MAX_EDGES + 1);

    logic [COUNT_REG_BITS-1:0]  r_node_count;
    logic [NODE_FIELD_BITS-1:0] r_src;
    logic [NODE_FIELD_BITS-1:0] r_tgt;

    logic [NODE_FIELD_BITS-1:0] m_ea [MAX_EDGES];
    logic [NODE_FIELD_BITS-1:0] m_eb [MAX_EDGES];
    logic [WEIGHT_BITS-1:0]     m_ew [MAX_EDGES];
    logic [NB-1:0]              m_par [MAX_NODES];
    logic [NC-1:0]              m_sz  [MAX_NODES];

    logic [EC-1:0]              r_cnt;
    logic [EC-1:0]              r_ei;
    logic [NC-1:0]              r_ni;
    logic [NODE_FIELD_BITS-1:0] r_ea;
    logic [NODE_FIELD_BITS-1:0] r_eb;
    logic [WEIGHT_BITS-1:0]     r_ew;
    logic [NB-1:0]              r_par;
    logic [NC-1:0]              r_sz;
    logic [NC-1:0]              r_sa;
    logic [NB-1:0]              r_cur;
    logic [NB-1:0]              r_ra;
    logic [NB-1:0]              r_rb;
    logic [WEIGHT_BITS-1:0]     r_thr;
    logic                       r_thr_v;
    logic [WEIGHT_BITS-1:0]     r_nxt;
    logic                       r_nxt_v;
    logic                       r_found;
    logic [RESULT_BITS-1:0]     r_bn;

    logic [NC-1:0] lim;
    logic          a_big;
    logic          par_we;
    logic [NB-1:0] par_wa;
    logic [NB-1:0] par_wd;
    logic          sz_we;
    logic [NB-1:0] sz_wa;
    logic [NC-1:0] sz_wd;
    logic [NB-1:0] sz_ra;
    logic          cand;
    logic [63:0]   thr_wide;

    assign lim = (32'(r_node_count) >= MAX_NODES) ? NC'(MAX_NODES) : NC'(r_node_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RESET;
            r_src        <= '0;
            r_tgt        <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NODE_COUNT:  r_node_count <= i_cfg_data;
                CFG_SOURCE_NODE: r_src <= i_cfg_data[NODE_FIELD_BITS-1:0];
                CFG_TARGET_NODE: r_tgt <= i_cfg_data[NODE_FIELD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Edge store: written while loading, read one entry per scan step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD && r_cnt < EC'(MAX_EDGES)) begin
            m_ea[r_cnt[EA-1:0]] <= i_end_a;
            m_eb[r_cnt[EA-1:0]] <= i_end_b;
            m_ew[r_cnt[EA-1:0]] <= i_weight;
        end
        if (i_cmd.op == OP_EDGE_RD) begin
            r_ea <= m_ea[r_ei[EA-1:0]];
            r_eb <= m_eb[r_ei[EA-1:0]];
            r_ew <= m_ew[r_ei[EA-1:0]];
        end
    end

    // The smaller tree hangs below the larger one; ties go to the second root.
    assign a_big = r_sa > r_sz;

    always_comb begin
        par_we = 1'b0;
        par_wa = r_ra;
        par_wd = r_rb;
        sz_we  = 1'b0;
        sz_wa  = r_rb;
        sz_wd  = NC'(r_sa + r_sz);
        case (i_cmd.op)
            OP_INIT_STEP: begin
                par_we = 1'b1;
                par_wa = r_ni[NB-1:0];
                par_wd = r_ni[NB-1:0];
                sz_we  = 1'b1;
                sz_wa  = r_ni[NB-1:0];
                sz_wd  = NC'(1);
            end
            OP_UNION: begin
                par_we = 1'b1;
                par_wa = a_big ? r_rb : r_ra;
                par_wd = a_big ? r_ra : r_rb;
                sz_we  = 1'b1;
                sz_wa  = a_big ? r_ra : r_rb;
            end
            default: ;
        endcase
    end

    assign sz_ra = (i_cmd.op == OP_SZ_RD_A) ? r_ra : r_rb;

    always_ff @(posedge i_clk) begin
        if (par_we) begin
            m_par[par_wa] <= par_wd;
        end
        if (sz_we) begin
            m_sz[sz_wa] <= sz_wd;
        end
        if (i_cmd.op == OP_PAR_RD) begin
            r_par <= m_par[r_cur];
        end
        if (i_cmd.op == OP_SZ_RD_A || i_cmd.op == OP_SZ_RD_B) begin
            r_sz <= m_sz[sz_ra];
        end
    end

    // Candidate for the next weight group: heaviest weight below the current one.
    assign cand = (!r_thr_v || r_ew < r_thr) && (!r_nxt_v || r_ew > r_nxt);
    assign thr_wide = 64'(r_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_thr_v <= 1'b0;
            r_nxt_v <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    if (r_cnt < EC'(MAX_EDGES)) begin
                        r_cnt <= r_cnt + EC'(1);
                    end
                end
                OP_INIT_BEGIN: begin
                    r_ni    <= '0;
                    r_thr_v <= 1'b0;
                    r_nxt_v <= 1'b0;
                end
                OP_INIT_STEP: r_ni <= r_ni + NC'(1);
                OP_SCAN_BEGIN: begin
                    r_ei <= '0;
                    if (r_nxt_v) begin
                        r_thr   <= r_nxt;
                        r_thr_v <= 1'b1;
                    end
                    r_nxt_v <= 1'b0;
                end
                OP_EDGE_RD: r_ei <= r_ei + EC'(1);
                OP_EDGE_USE: begin
                    if (cand) begin
                        r_nxt   <= r_ew;
                        r_nxt_v <= 1'b1;
                    end
                    r_cur <= NB'(r_ea);
                end
                OP_STEP: r_cur <= r_par;
                OP_ROOT_A_EDGE: begin
                    r_ra  <= r_cur;
                    r_cur <= NB'(r_eb);
                end
                OP_ROOT_A_QUERY: begin
                    r_ra  <= r_cur;
                    r_cur <= NB'(r_tgt);
                end
                OP_ROOT_B: r_rb <= r_cur;
                OP_CUR_SRC: r_cur <= NB'(r_src);
                OP_SZ_RD_B: r_sa <= r_sz;
                OP_FOUND: begin
                    r_found <= 1'b1;
                    r_bn    <= thr_wide[RESULT_BITS-1:0];
                    r_cnt   <= '0;
                end
                OP_NOT_FOUND: begin
                    r_found <= 1'b0;
                    r_bn    <= '0;
                    r_cnt   <= '0;
                end
                default: ;
            endcase
        end
    end

    assign o_sts.query_ok  = (r_src < lim) && (r_tgt < lim) && (r_cnt != '0);
    assign o_sts.init_last = (r_ni == lim - NC'(1));
    assign o_sts.merge_hit = r_thr_v && (r_ew == r_thr) && (r_ea < lim) && (r_eb < lim);
    assign o_sts.scan_done = (r_ei == r_cnt);
    assign o_sts.root_hit  = (r_par == r_cur);
    assign o_sts.same_root = (r_ra == r_rb);
    assign o_sts.thr_valid = r_thr_v;
    assign o_sts.nxt_valid = r_nxt_v;

    assign o_found      = r_found;
    assign o_bottleneck = r_bn;
endmodule

@@ src/mbp_ctrl.sv @@
// Controller: sequences edge loading, forest initialisation, the weight-group
// scans, the root walks and the unions. Drives the datapath by command; uses mbp_pkg.
module mbp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last_edge,
    input  logic          i_out_ready,
    input  mbp_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output mbp_pkg::t_cmd o_cmd
);
    import mbp_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD, S_START, S_INIT, S_SB, S_ERD, S_EUSE, S_ENEXT,
        S_FA_RD, S_FA_CHK, S_FB_RD, S_FB_CHK, S_CMP, S_SZB, S_UNI,
        S_QA_RD, S_QA_CHK, S_QB_RD, S_QB_CHK, S_QCMP, S_FIN_F, S_FIN_NF
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_v;
    logic   n_out_v;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    if (i_last_edge) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                if (i_sts.query_ok) begin
                    o_cmd.op = OP_INIT_BEGIN;
                    n_state  = S_INIT;
                end else begin
                    n_state = S_FIN_NF;
                end
            end
            S_INIT: begin
                o_cmd.op = OP_INIT_STEP;
                if (i_sts.init_last) begin
                    n_state = S_SB;
                end
            end
            S_SB: begin
                o_cmd.op = OP_SCAN_BEGIN;
                n_state  = S_ERD;
            end
            S_ERD: begin
                o_cmd.op = OP_EDGE_RD;
                n_state  = S_EUSE;
            end
            S_EUSE: begin
                o_cmd.op = OP_EDGE_USE;
                n_state  = i_sts.merge_hit ? S_FA_RD : S_ENEXT;
            end
            S_ENEXT: begin
                if (!i_sts.scan_done) begin
                    n_state = S_ERD;
                end else if (i_sts.thr_valid) begin
                    o_cmd.op = OP_CUR_SRC;
                    n_state  = S_QA_RD;
                end else begin
                    // The first pass only finds the heaviest weight.
                    n_state = S_SB;
                end
            end
            S_FA_RD: begin
                o_cmd.op = OP_PAR_RD;
                n_state  = S_FA_CHK;
            end
            S_FA_CHK: begin
                o_cmd.op = i_sts.root_hit ? OP_ROOT_A_EDGE : OP_STEP;
                n_state  = i_sts.root_hit ? S_FB_RD : S_FA_RD;
            end
            S_FB_RD: begin
                o_cmd.op = OP_PAR_RD;
                n_state  = S_FB_CHK;
            end
            S_FB_CHK: begin
                o_cmd.op = i_sts.root_hit ? OP_ROOT_B : OP_STEP;
                n_state  = i_sts.root_hit ? S_CMP : S_FB_RD;
            end
            S_CMP: begin
                if (i_sts.same_root) begin
                    n_state = S_ENEXT;
                end else begin
                    o_cmd.op = OP_SZ_RD_A;
                    n_state  = S_SZB;
                end
            end
            S_SZB: begin
                o_cmd.op = OP_SZ_RD_B;
                n_state  = S_UNI;
            end
            S_UNI: begin
                o_cmd.op = OP_UNION;
                n_state  = S_ENEXT;
            end
            S_QA_RD: begin
                o_cmd.op = OP_PAR_RD;
                n_state  = S_QA_CHK;
            end
            S_QA_CHK: begin
                o_cmd.op = i_sts.root_hit ? OP_ROOT_A_QUERY : OP_STEP;
                n_state  = i_sts.root_hit ? S_QB_RD : S_QA_RD;
            end
            S_QB_RD: begin
                o_cmd.op = OP_PAR_RD;
                n_state  = S_QB_CHK;
            end
            S_QB_CHK: begin
                o_cmd.op = i_sts.root_hit ? OP_ROOT_B : OP_STEP;
                n_state  = i_sts.root_hit ? S_QCMP : S_QB_RD;
            end
            S_QCMP: begin
                if (i_sts.same_root) begin
                    n_state = S_FIN_F;
                end else if (i_sts.nxt_valid) begin
                    n_state = S_SB;
                end else begin
                    n_state = S_FIN_NF;
                end
            end
            S_FIN_F: begin
                if (!r_out_v) begin
                    o_cmd.op = OP_FOUND;
                    n_state  = S_LOAD;
                end
            end
            S_FIN_NF: begin
                if (!r_out_v) begin
                    o_cmd.op = OP_NOT_FOUND;
                    n_state  = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        n_out_v = r_out_v;
        if (r_out_v && i_out_ready) begin
            n_out_v = 1'b0;
        end
        if (o_cmd.op == OP_FOUND || o_cmd.op == OP_NOT_FOUND) begin
            n_out_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_v <= n_out_v;
        end
    end

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_out_v;
endmodule

@@ src/max_bottleneck_path.sv @@
// Top level of the maximum bottleneck path block: joins controller and datapath.
// Depends on mbp_pkg, mbp_in_if, mbp_out_if, mbp_ctrl and mbp_datapath.
//
// Edge words load one per cycle into the edge store while no computation runs. The
// word marked last starts a computation. A start state checks the query and, if it
// holds, the forest is initialised node by node below the node limit, which is
// node_count but at most MAX_NODES. A first pass over the stored edges finds the
// heaviest weight. After it the edges are scanned once per distinct weight, heaviest
// first. Each pass has a set-up state and then takes each edge through a read, a use
// and an advance state. An edge of the current weight with both endpoints in range also
// walks to both of its roots, through a read and a check state per node visited with
// the root included. Its roots are then compared, and when they differ both tree sizes
// are read and a union follows. After each weight group the roots of source and target
// are found in the same way and compared. The scans are bound by the single read port
// of the edge store. The result is then written once the output register is free.
// While a computation runs no edge word is taken; a finished result waits in the
// output register while the next graph loads.
module max_bottleneck_path #(
    parameter int unsigned MAX_NODES   = mbp_pkg::DEF_MAX_NODES,
    parameter int unsigned MAX_EDGES   = mbp_pkg::DEF_MAX_EDGES,
    parameter int unsigned WEIGHT_BITS = mbp_pkg::DEF_WEIGHT_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mbp_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [mbp_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    mbp_in_if.sink                            i_in,
    mbp_out_if.source                         o_out
);
    import mbp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    mbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_last_edge (i_in.last_edge),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    mbp_datapath #(
        .MAX_NODES   (MAX_NODES),
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd),
        .i_end_a      (i_in.end_a),
        .i_end_b      (i_in.end_b),
        .i_weight     (i_in.weight),
        .o_sts        (sts),
        .o_found      (o_out.found),
        .o_bottleneck (o_out.bottleneck)
    );
endmodule

@@ src/mbp_checker.sv @@
// Port-level checks for the maximum bottleneck path block, bound to the top level.
// Depends on mbp_pkg for the result width.
module mbp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_last_edge,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic                              i_found,
    input logic [mbp_pkg::RESULT_BITS-1:0]   i_bottleneck
);
    // A word that is not found carries a zero weight.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_found) |-> (i_bottleneck == '0))
        else $error("not-found result with nonzero bottleneck");

    // The last edge word starts a computation, so no edge is taken next cycle.
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_last_edge) |=> !i_in_ready)
        else $error("edge accepted straight after the last edge");

    // No result straight out of reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_found) && $stable(i_bottleneck)))
        else $error("result changed while stalled");
endmodule

bind max_bottleneck_path mbp_checker u_mbp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_last_edge  (i_in.last_edge),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_found      (o_out.found),
    .i_bottleneck (o_out.bottleneck)
);

@@ test/max_bottleneck_path_tb.sv @@
// Self-checking testbench for max_bottleneck_path: drives graphs of edge words and
// compares each bottleneck result with an in-bench Kruskal and union-find predictor.
// Depends on mbp_pkg, mbp_in_if, mbp_out_if and the max_bottleneck_path RTL.
module max_bottleneck_path_tb;
    import mbp_pkg::*;

    localparam int unsigned NODES = DEF_MAX_NODES;
    localparam int unsigned EDGES = DEF_MAX_EDGES;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_IDX = 2'd3;
    localparam int STALL_LIMIT = 2000000;
    localparam int ITEM_TARGET = 1050;

    typedef struct packed {
        logic [NODE_FIELD_BITS-1:0] end_a;
        logic [NODE_FIELD_BITS-1:0] end_b;
        logic [31:0]                weight;
        logic                       last_edge;
    } t_edge;

    typedef struct packed {
        logic        found;
        logic [31:0] bottleneck;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    mbp_in_if #(.WEIGHT_BITS(DEF_WEIGHT_BITS)) in_ch ();
    mbp_out_if out_ch ();

    max_bottleneck_path u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    t_edge   edge_q[$];
    t_answer answer_q[$];
    int      mismatches = 0;
    int      edges_sent = 0;
    int      idle_cycles = 0;

    // Predictor state: our own copy of the registers, edge store and forest.
    logic [COUNT_REG_BITS-1:0]  nc_reg = NODE_COUNT_RESET;
    logic [NODE_FIELD_BITS-1:0] src_reg = '0;
    logic [NODE_FIELD_BITS-1:0] tgt_reg = '0;
    logic [NODE_FIELD_BITS-1:0] store_a [EDGES];
    logic [NODE_FIELD_BITS-1:0] store_b [EDGES];
    logic [31:0]                store_w [EDGES];
    int                         stored = 0;
    int                         forest_up [NODES];
    int                         forest_sz [NODES];
    int                         order [EDGES];

    function automatic int find_root(int v);
        int r;
        int nx;
        r = v;
        while (forest_up[r] != r) r = forest_up[r];
        while (forest_up[v] != r) begin
            nx = forest_up[v];
            forest_up[v] = r;
            v = nx;
        end
        return r;
    endfunction

    function automatic void join_sets(int a, int b);
        int x;
        int y;
        int t;
        x = find_root(a);
        y = find_root(b);
        if (x != y) begin
            if (forest_sz[x] > forest_sz[y]) begin
                t = x; x = y; y = t;
            end
            forest_sz[y] += forest_sz[x];
            forest_sz[x] = 0;
            forest_up[x] = y;
        end
    endfunction

    // Stores an accepted edge; the last one of a graph yields the expected answer.
    function automatic void take_edge(t_edge e);
        int lim;
        int j;
        int key;
        t_answer ans;
        if (stored < EDGES) begin
            store_a[stored] = e.end_a;
            store_b[stored] = e.end_b;
            store_w[stored] = e.weight;
            stored++;
        end
        if (!e.last_edge) return;
        lim = (nc_reg < NODES) ? int'(nc_reg) : NODES;
        for (int i = 0; i < lim; i++) begin
            forest_up[i] = i;
            forest_sz[i] = 1;
        end
        ans = '0;
        if (src_reg < lim && tgt_reg < lim && stored > 0) begin
            for (int i = 0; i < stored; i++) begin
                key = i;
                j = i - 1;
                while (j >= 0 && store_w[order[j]] < store_w[key]) begin
                    order[j+1] = order[j];
                    j--;
                end
                order[j+1] = key;
            end
            for (int i = 0; i < stored; i++) begin
                key = order[i];
                if (store_a[key] < lim && store_b[key] < lim)
                    join_sets(store_a[key], store_b[key]);
                if (find_root(src_reg) == find_root(tgt_reg)) begin
                    ans.found = 1'b1;
                    ans.bottleneck = store_w[key];
                    break;
                end
            end
        end
        stored = 0;
        answer_q = {answer_q, ans};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sender: a word is held until taken; gaps fall between words.
    int send_gap = 0;
    bit send_calm = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                take_edge('{in_ch.end_a, in_ch.end_b, in_ch.weight, in_ch.last_edge});
            if (!in_ch.valid || in_ch.ready) begin
                if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (edge_q.size() > 0) begin
                    t_edge e;
                    e = edge_q.pop_front();
                    in_ch.end_a <= e.end_a;
                    in_ch.end_b <= e.end_b;
                    in_ch.weight <= e.weight;
                    in_ch.last_edge <= e.last_edge;
                    in_ch.valid <= 1'b1;
                    edges_sent++;
                    send_gap = send_calm ? 0 : pick_gap();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure, each result word checked against the oldest answer.
    int recv_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (answer_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: found=%0b bottleneck=%0d",
                                 out_ch.found, out_ch.bottleneck);
                end else begin
                    t_answer ans;
                    ans = answer_q.pop_front();
                    if (out_ch.found !== ans.found ||
                        out_ch.bottleneck !== ans.bottleneck) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: expected found=%0b bottleneck=%0d,",
                                      " got found=%0b bottleneck=%0d"},
                                     ans.found, ans.bottleneck,
                                     out_ch.found, out_ch.bottleneck);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic wait_drained();
        while (edge_q.size() > 0 || in_ch.valid || answer_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[CFG_DATA_BITS-1:0];
        case (idx)
            CFG_NODE_COUNT:  nc_reg = val[COUNT_REG_BITS-1:0];
            CFG_SOURCE_NODE: src_reg = val[NODE_FIELD_BITS-1:0];
            CFG_TARGET_NODE: tgt_reg = val[NODE_FIELD_BITS-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_query(int unsigned nc, int unsigned src, int unsigned tgt);
        wait_drained();
        write_reg(CFG_NODE_COUNT, nc);
        write_reg(CFG_SOURCE_NODE, src);
        write_reg(CFG_TARGET_NODE, tgt);
    endtask

    task automatic add_edge(int unsigned a, int unsigned b, logic [31:0] w, bit last);
        t_edge e;
        e = '{a[9:0], b[9:0], w, last};
        edge_q = {edge_q, e};
    endtask

    // A random graph whose weights come from a small pool, so few distinct weights.
    task automatic random_graph(int unsigned n, int unsigned span);
        logic [31:0] pool [4];
        int unsigned a;
        int unsigned b;
        for (int i = 0; i < 4; i++)
            pool[i] = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                a = $urandom_range(0, 1023);
                b = $urandom_range(0, 1023);
            end else begin
                a = $urandom_range(0, span);
                b = $urandom_range(0, span);
            end
            add_edge(a, b, pool[$urandom_range(0, 3)], i == n - 1);
        end
    endtask

    initial begin
        int unsigned nc;
        int unsigned span;
        in_ch.valid = 1'b0;
        in_ch.end_a = '0;
        in_ch.end_b = '0;
        in_ch.weight = '0;
        in_ch.last_edge = 1'b0;
        out_ch.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Source equals target after reset: the heaviest weight is reported.
        add_edge(1, 2, 32'd7, 0);
        add_edge(1023, 0, 32'hFFFF_FFFF, 0);
        add_edge(3, 3, 32'd0, 1);
        wait_drained();
        write_reg(CFG_SPARE_IDX, 11'h7FF);
        add_edge(5, 6, 32'd9, 1);

        // Chain with an out-of-range endpoint and a zero weight.
        set_query(4, 0, 3);
        add_edge(0, 1, 32'd50, 0);
        add_edge(2, 1023, 32'd90, 0);
        add_edge(1, 2, 32'd40, 0);
        add_edge(2, 3, 32'd0, 1);
        add_edge(0, 1, 32'd5, 1);

        set_query(0, 0, 0);
        add_edge(0, 0, 32'd3, 1);
        set_query(2047, 1023, 0);
        add_edge(1023, 0, 32'h8000_0001, 1);
        set_query(8, 9, 2);
        add_edge(9, 2, 32'd4, 1);
        set_query(1, 0, 0);
        add_edge(0, 0, 32'd12, 1);

        while (edges_sent + edge_q.size() < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0: nc = 1024;
                1: nc = $urandom_range(1025, 2047);
                2: nc = $urandom_range(0, 1);
                default: nc = $urandom_range(2, 16);
            endcase
            span = (nc == 0) ? 1 : ((nc > 1023) ? 1023 : nc);
            if ($urandom_range(0, 7) == 0)
                set_query(nc, $urandom_range(0, 1023), $urandom_range(0, 1023));
            else
                set_query(nc, $urandom_range(0, span), $urandom_range(0, span));
            repeat ($urandom_range(1, 6))
                random_graph(($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                          : $urandom_range(1, 12), span);
        end

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && answer_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
